>>> sv/crc_framed_table_read_responder_top_macros.svh
`ifndef CRC_FRAMED_TABLE_READ_RESPONDER_TOP_MACROS_SVH
`define CRC_FRAMED_TABLE_READ_RESPONDER_TOP_MACROS_SVH

// same-cycle implication
`define CRCF_ASSERT_IMPL(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define CRCF_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/crcf_pkg.sv
package crcf_pkg;

   localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
   localparam logic [31:0] CRC_ONES = 32'hFFFF_FFFF;

   localparam logic [7:0] HDR_ZERO = 8'h00;
   localparam logic [7:0] HDR_SEVEN = 8'h07;
   localparam logic [7:0] HDR_READ = 8'h72;

   localparam logic [3:0] POS_FIRST = 4'd0;
   localparam logic [3:0] POS_LAST = 4'd12;

   localparam logic OP_RX = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   typedef struct packed {
      logic       load_ones;
      logic       feed;
      logic [7:0] data;
   } crc_cmd_type;

   typedef struct packed {
      logic        busy;
      logic [31:0] value;
   } crc_stat_type;

endpackage

>>> sv/crcf_ifs.sv
interface crcf_req_if;
   logic       valid;
   logic       ready;
   logic       opcode;
   logic [7:0] rx_byte;
   logic [4:0] table_address;
   logic [7:0] table_data;

   modport source(output valid, opcode, rx_byte, table_address, table_data, input ready);
   modport sink(input valid, opcode, rx_byte, table_address, table_data, output ready);
endinterface

interface crcf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] tx_byte;
   logic       frame_end;

   modport source(output valid, tx_byte, frame_end, input ready);
   modport sink(input valid, tx_byte, frame_end, output ready);
endinterface

>>> sv/crc_framed_table_read_responder_top.sv
// link bytes: one request per cycle while idle, but bytes 2 to 8 of a frame keep the
// bit-serial crc unit busy, which holds off the next request; reply: after the last
// request byte the length state registers the first reply byte; length and zero bytes
// at 1 per cycle, each slice byte and the first crc byte once the crc unit is done with
// the byte before, last 3 crc bytes at 1 per cycle; requests wait until the reply is out;
// stalls add cycles; synchronous active-high reset clears parser, crc and table
`include "crc_framed_table_read_responder_top_macros.svh"

module crc_framed_table_read_responder_top #(
   parameter int TABLE_BYTES = 32
) (
   input logic        clock,
   input logic        reset,
   crcf_req_if.sink   req_if,
   crcf_rsp_if.source rsp_if
);
   import crcf_pkg::*;

   localparam int AW = (TABLE_BYTES > 1) ? $clog2(TABLE_BYTES) : 1;
   localparam int SZW = $clog2(TABLE_BYTES + 1);
   localparam logic [16:0] TB17 = 17'(TABLE_BYTES);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_LEN = 3'd1;
   localparam logic [2:0] ST_RD = 3'd2;
   localparam logic [2:0] ST_DATA = 3'd3;
   localparam logic [2:0] ST_TAIL = 3'd4;

   logic [2:0]     state_ff, state_in;
   logic [3:0]     pos_ff, pos_in;
   logic [15:0]    off_ff, off_in;
   logic [15:0]    size_ff, size_in;
   logic [31:0]    rcv_ff, rcv_in;
   logic [AW-1:0]  rep_off_ff, rep_off_in;
   logic [SZW-1:0] rep_size_ff, rep_size_in;
   logic [SZW-1:0] idx_ff, idx_in;
   logic [1:0]     step_ff, step_in;
   logic           zpad_ff, zpad_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [7:0]     tx_ff, tx_in;
   logic           end_ff, end_in;

   crc_cmd_type  crc_cmd;
   crc_stat_type crc_stat;

   logic          accept;
   logic          out_free;
   logic [7:0]    b;
   logic [31:0]   rcv_full;
   logic [16:0]   sum17;
   logic [16:0]   clip17;
   logic [15:0]   len16;
   logic [31:0]   crc_fin;
   logic [SZW:0]  idx_next;
   logic [SZW:0]  addr_up;
   logic [SZW:0]  addr_dn;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic [7:0]    rd_data;

   crcf_crc_unit u_crc (
      .clock (clock),
      .reset (reset),
      .cmd   (crc_cmd),
      .stat  (crc_stat)
   );

   crcf_table #(
      .TABLE_BYTES (TABLE_BYTES),
      .AW          (AW)
   ) u_table (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_if.table_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_if.ready = (state_ff == ST_IDLE) && !crc_stat.busy;
   assign accept = req_if.valid && req_if.ready;
   assign out_free = !rsp_valid_ff || rsp_if.ready;
   assign b = req_if.rx_byte;
   assign rcv_full = {rcv_ff[23:0], b};
   assign sum17 = {1'b0, size_ff} + {1'b0, off_ff};
   assign clip17 = TB17 - {1'b0, off_ff};
   assign len16 = 16'(rep_size_ff) + 16'd1;
   assign crc_fin = ~crc_stat.value;
   assign idx_next = (SZW + 1)'(idx_ff) + (SZW + 1)'(1);
   assign addr_up = (SZW + 1)'(rep_off_ff) + idx_next;
   assign addr_dn = (SZW + 1)'(rep_off_ff) + (SZW + 1)'(idx_ff) - (SZW + 1)'(1);

   assign wr_en = accept && (req_if.opcode == OP_WRITE)
      && (32'(req_if.table_address) < 32'(TABLE_BYTES));
   assign wr_addr = AW'(req_if.table_address);

   always_comb begin
      state_in = state_ff;
      pos_in = pos_ff;
      off_in = off_ff;
      size_in = size_ff;
      rcv_in = rcv_ff;
      rep_off_in = rep_off_ff;
      rep_size_in = rep_size_ff;
      idx_in = idx_ff;
      step_in = step_ff;
      zpad_in = zpad_ff;
      rsp_valid_in = rsp_valid_ff;
      tx_in = tx_ff;
      end_in = end_ff;
      crc_cmd = '0;
      rd_en = 1'b0;
      rd_addr = addr_up[AW-1:0];

      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_if.opcode == OP_RX)) begin
               unique case (pos_ff)
                  4'd0: begin
                     if (b == HDR_ZERO) begin
                        pos_in = 4'd1;
                     end
                  end
                  4'd1: begin
                     pos_in = (b == HDR_SEVEN) ? 4'd2 : POS_FIRST;
                     crc_cmd.load_ones = 1'b1;
                  end
                  4'd2: begin
                     crc_cmd.load_ones = 1'b1;
                     if (b == HDR_READ) begin
                        crc_cmd.feed = 1'b1;
                        crc_cmd.data = b;
                        pos_in = 4'd3;
                     end else begin
                        pos_in = POS_FIRST;
                     end
                  end
                  4'd3, 4'd4: begin
                     if (b == ((pos_ff == 4'd3) ? HDR_ZERO : HDR_SEVEN)) begin
                        crc_cmd.feed = 1'b1;
                        crc_cmd.data = b;
                        pos_in = pos_ff + 4'd1;
                     end else begin
                        crc_cmd.load_ones = 1'b1;
                        pos_in = POS_FIRST;
                     end
                  end
                  4'd5, 4'd6: begin
                     off_in = {off_ff[7:0], b};
                     crc_cmd.feed = 1'b1;
                     crc_cmd.data = b;
                     pos_in = pos_ff + 4'd1;
                  end
                  4'd7, 4'd8: begin
                     size_in = {size_ff[7:0], b};
                     crc_cmd.feed = 1'b1;
                     crc_cmd.data = b;
                     pos_in = pos_ff + 4'd1;
                  end
                  4'd9, 4'd10, 4'd11: begin
                     rcv_in = rcv_full;
                     pos_in = pos_ff + 4'd1;
                  end
                  POS_LAST: begin
                     rcv_in = rcv_full;
                     pos_in = POS_FIRST;
                     crc_cmd.load_ones = 1'b1;
                     if ((crc_fin == rcv_full) && ({1'b0, off_ff} < TB17)) begin
                        rep_off_in = off_ff[AW-1:0];
                        rep_size_in = (sum17 > TB17) ? clip17[SZW-1:0] : size_ff[SZW-1:0];
                        step_in = 2'd0;
                        state_in = ST_LEN;
                     end
                  end
                  default: begin
                     crc_cmd.load_ones = 1'b1;
                     pos_in = POS_FIRST;
                  end
               endcase
            end
         end
         ST_LEN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               end_in = 1'b0;
               unique case (step_ff)
                  2'd0: tx_in = len16[15:8];
                  2'd1: tx_in = len16[7:0];
                  default: tx_in = 8'd0;
               endcase
               step_in = step_ff + 2'd1;
               if (step_ff == 2'd2) begin
                  // crc register is all ones here after the request check
                  crc_cmd.feed = 1'b1;
                  crc_cmd.data = 8'd0;
                  idx_in = '0;
                  state_in = ST_RD;
               end
            end
         end
         ST_RD: begin
            if (idx_ff == rep_size_ff) begin
               step_in = 2'd0;
               state_in = ST_TAIL;
            end else begin
               // adjacent bytes swapped, unpaired last byte sent as zero
               if (!idx_ff[0]) begin
                  zpad_in = !(idx_next < (SZW + 1)'(rep_size_ff));
                  rd_addr = addr_up[AW-1:0];
               end else begin
                  zpad_in = 1'b0;
                  rd_addr = addr_dn[AW-1:0];
               end
               rd_en = 1'b1;
               state_in = ST_DATA;
            end
         end
         ST_DATA: begin
            if (out_free && !crc_stat.busy) begin
               rsp_valid_in = 1'b1;
               end_in = 1'b0;
               tx_in = zpad_ff ? 8'd0 : rd_data;
               crc_cmd.feed = 1'b1;
               crc_cmd.data = zpad_ff ? 8'd0 : rd_data;
               idx_in = idx_next[SZW-1:0];
               state_in = ST_RD;
            end
         end
         ST_TAIL: begin
            if (out_free && !crc_stat.busy) begin
               rsp_valid_in = 1'b1;
               unique case (step_ff)
                  2'd0: tx_in = crc_fin[31:24];
                  2'd1: tx_in = crc_fin[23:16];
                  2'd2: tx_in = crc_fin[15:8];
                  2'd3: tx_in = crc_fin[7:0];
               endcase
               end_in = (step_ff == 2'd3);
               step_in = step_ff + 2'd1;
               if (step_ff == 2'd3) begin
                  crc_cmd.load_ones = 1'b1;
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pos_ff <= POS_FIRST;
         off_ff <= '0;
         size_ff <= '0;
         rcv_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pos_ff <= pos_in;
         off_ff <= off_in;
         size_ff <= size_in;
         rcv_ff <= rcv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rep_off_ff <= rep_off_in;
      rep_size_ff <= rep_size_in;
      idx_ff <= idx_in;
      step_ff <= step_in;
      zpad_ff <= zpad_in;
      tx_ff <= tx_in;
      end_ff <= end_in;
   end

   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.tx_byte = tx_ff;
   assign rsp_if.frame_end = end_ff;

   `CRCF_ASSERT_IMPL(a_feed_when_idle, clock, reset, crc_cmd.feed, !crc_stat.busy, "crc fed while busy")
   `CRCF_ASSERT_NEXT(a_last_restarts, clock, reset, accept && (req_if.opcode == OP_RX) && (pos_ff == POS_LAST), pos_ff == POS_FIRST, "parser did not restart after last byte")
   `CRCF_ASSERT_IMPL(a_idx_in_range, clock, reset, (state_ff == ST_RD) || (state_ff == ST_DATA), idx_ff <= rep_size_ff, "slice index past size")

endmodule

>>> sv/crcf_crc_unit.sv
module crcf_crc_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  crcf_pkg::crc_cmd_type cmd,
   output crcf_pkg::crc_stat_type stat
);
   import crcf_pkg::*;

   logic [31:0] crc_ff, crc_in;
   logic [7:0]  dat_ff, dat_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic        fb;

   // bit-serial reflected crc, one data bit per cycle
   always_comb begin
      crc_in = crc_ff;
      dat_in = dat_ff;
      cnt_in = cnt_ff;
      fb = crc_ff[0] ^ dat_ff[0];
      if (cnt_ff != 4'd0) begin
         crc_in = (crc_ff >> 1) ^ (fb ? CRC_POLY : 32'd0);
         dat_in = dat_ff >> 1;
         cnt_in = cnt_ff - 4'd1;
      end else begin
         if (cmd.load_ones) begin
            crc_in = CRC_ONES;
         end
         if (cmd.feed) begin
            dat_in = cmd.data;
            cnt_in = 4'd8;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff <= CRC_ONES;
         cnt_ff <= 4'd0;
      end else begin
         crc_ff <= crc_in;
         cnt_ff <= cnt_in;
      end
      dat_ff <= dat_in;
   end

   assign stat.busy = (cnt_ff != 4'd0);
   assign stat.value = crc_ff;

endmodule

>>> sv/crcf_table.sv
module crcf_table #(
   parameter int TABLE_BYTES = 32,
   parameter int AW = 5
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data
);
   logic [7:0]             mem [TABLE_BYTES];
   logic [TABLE_BYTES-1:0] valid_ff;
   logic [7:0]             rd_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // entries never written read as zero
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= valid_ff[rd_addr] ? mem[rd_addr] : 8'd0;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   import crcf_pkg::*;

   localparam int TABLE_BYTES = 32;
   localparam int END_DRAIN = 500;
   localparam int STALL_CYCLES = 700;
   localparam int RANDOM_ITEMS = 350;

   typedef struct packed {
      logic       opcode;
      logic [7:0] rx_byte;
      logic [4:0] table_address;
      logic [7:0] table_data;
   } link_item_type;

   typedef struct packed {
      logic [7:0] tx_byte;
      logic       frame_end;
   } reply_byte_type;

   logic clock;
   logic reset;

   crcf_req_if req();
   crcf_rsp_if rsp();

   crc_framed_table_read_responder_top #(
      .TABLE_BYTES(TABLE_BYTES)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_if(req),
      .rsp_if(rsp)
   );

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   link_item_type  link_q[$];
   reply_byte_type reply_q[$];
   link_item_type  offered;
   int          error_count = 0;
   int          stim_count = 0;
   bit          mix_writes = 1'b0;
   int          cycle_count = 0;
   bit          quiet;
   int          hold_left;
   bit          hold_done;

   // parser and table copy
   logic [3:0]  frame_pos = POS_FIRST;
   logic [15:0] req_offset = '0;
   logic [15:0] req_size = '0;
   logic [31:0] req_crc = CRC_ONES;
   logic [31:0] got_crc = '0;
   logic [7:0]  table_mem[TABLE_BYTES];

   function automatic logic [31:0] crc32_step(input logic [31:0] c, input logic [7:0] b);
      logic [31:0] r;
      r = c ^ {24'h0, b};
      for (int k = 0; k < 8; k++) begin
         r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
      end
      return r;
   endfunction

   task automatic expect_reply();
      int          off;
      int          span;
      logic [15:0] len;
      logic [31:0] c;
      logic [7:0]  b;
      off = req_offset;
      span = req_size;
      if (off >= TABLE_BYTES) begin
         return;
      end
      if (span + off > TABLE_BYTES) begin
         span = TABLE_BYTES - off;
      end
      len = 16'(span + 1);
      reply_q.push_back('{len[15:8], 1'b0});
      reply_q.push_back('{len[7:0], 1'b0});
      reply_q.push_back('{8'h00, 1'b0});
      c = crc32_step(CRC_ONES, 8'h00);
      for (int i = 0; i < span; i++) begin
         // pairs swapped, an unpaired last byte goes out as zero
         if (i % 2 == 0) begin
            b = (i + 1 < span) ? table_mem[off + i + 1] : 8'h00;
         end else begin
            b = table_mem[off + i - 1];
         end
         reply_q.push_back('{b, 1'b0});
         c = crc32_step(c, b);
      end
      c = ~c;
      reply_q.push_back('{c[31:24], 1'b0});
      reply_q.push_back('{c[23:16], 1'b0});
      reply_q.push_back('{c[15:8], 1'b0});
      reply_q.push_back('{c[7:0], 1'b1});
   endtask

   task automatic restart_parse();
      frame_pos = POS_FIRST;
      req_crc = CRC_ONES;
   endtask

   task automatic parse_and_reply(input link_item_type it);
      logic [7:0] b;
      b = it.rx_byte;
      if (it.opcode == OP_WRITE) begin
         table_mem[it.table_address] = it.table_data;
         return;
      end
      case (frame_pos)
         4'd0: begin
            if (b == HDR_ZERO) frame_pos = 4'd1;
         end
         4'd1: begin
            if (b != HDR_SEVEN) restart_parse();
            else frame_pos = 4'd2;
         end
         4'd2: begin
            if (b != HDR_READ) begin
               restart_parse();
            end else begin
               req_crc = crc32_step(CRC_ONES, b);
               frame_pos = 4'd3;
            end
         end
         4'd3, 4'd4: begin
            if (b != ((frame_pos == 4'd3) ? HDR_ZERO : HDR_SEVEN)) begin
               restart_parse();
            end else begin
               req_crc = crc32_step(req_crc, b);
               frame_pos = frame_pos + 4'd1;
            end
         end
         4'd5, 4'd6: begin
            req_offset = {req_offset[7:0], b};
            req_crc = crc32_step(req_crc, b);
            frame_pos = frame_pos + 4'd1;
         end
         4'd7, 4'd8: begin
            req_size = {req_size[7:0], b};
            req_crc = crc32_step(req_crc, b);
            frame_pos = frame_pos + 4'd1;
         end
         4'd9, 4'd10, 4'd11: begin
            got_crc = {got_crc[23:0], b};
            frame_pos = frame_pos + 4'd1;
         end
         POS_LAST: begin
            got_crc = {got_crc[23:0], b};
            if (~req_crc == got_crc) begin
               restart_parse();
               expect_reply();
            end else begin
               restart_parse();
            end
         end
         default: restart_parse();
      endcase
   endtask

   // stimulus builders
   task automatic push_link_byte(input logic [7:0] b, input bit counted);
      link_q.push_back('{OP_RX, b, 5'($urandom), 8'($urandom)});
      if (counted) stim_count++;
   endtask

   task automatic push_table_write(input logic [4:0] a, input logic [7:0] d);
      link_q.push_back('{OP_WRITE, 8'($urandom), a, d});
      stim_count++;
   endtask

   task automatic push_request(input logic [15:0] off, input logic [15:0] size, input bit bad);
      logic [7:0]  bytes[13];
      logic [31:0] c;
      bytes[0] = HDR_ZERO;
      bytes[1] = HDR_SEVEN;
      bytes[2] = HDR_READ;
      bytes[3] = HDR_ZERO;
      bytes[4] = HDR_SEVEN;
      bytes[5] = off[15:8];
      bytes[6] = off[7:0];
      bytes[7] = size[15:8];
      bytes[8] = size[7:0];
      c = CRC_ONES;
      for (int i = 2; i <= 8; i++) c = crc32_step(c, bytes[i]);
      c = ~c;
      {bytes[9], bytes[10], bytes[11], bytes[12]} = c;
      if (bad) begin
         bytes[9 + $urandom_range(0, 3)] ^= 8'(1 << $urandom_range(0, 7));
      end
      for (int i = 0; i < 13; i++) begin
         if (mix_writes && $urandom_range(0, 99) < 5) begin
            push_table_write(5'($urandom), 8'($urandom));
         end
         push_link_byte(bytes[i], 1'b1);
      end
   endtask

   // header cut short by a wrong byte at position k
   task automatic push_broken_header(input int k);
      logic [7:0] hdr[5];
      hdr[0] = HDR_ZERO;
      hdr[1] = HDR_SEVEN;
      hdr[2] = HDR_READ;
      hdr[3] = HDR_ZERO;
      hdr[4] = HDR_SEVEN;
      for (int i = 0; i < k; i++) push_link_byte(hdr[i], 1'b1);
      push_link_byte(hdr[k] ^ 8'($urandom_range(1, 255)), 1'b1);
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // one window where neither side idles
   assign quiet = (cycle_count >= 3000) && (cycle_count < 7000);

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
         req.opcode <= OP_RX;
         req.rx_byte <= '0;
         req.table_address <= '0;
         req.table_data <= '0;
      end else begin
         if (req.valid && req.ready) parse_and_reply(offered);
         if (!req.valid || req.ready) begin
            if (link_q.size() != 0 && (quiet || $urandom_range(0, 99) >= 15)) begin
               offered = link_q.pop_front();
               req.valid <= 1'b1;
               req.opcode <= offered.opcode;
               req.rx_byte <= offered.rx_byte;
               req.table_address <= offered.table_address;
               req.table_data <= offered.table_data;
            end else begin
               req.valid <= 1'b0;
            end
         end
      end
   end

   // long output hold-off once a reply is under way
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (!hold_done && rsp.valid && cycle_count >= 600) begin
         hold_left <= STALL_CYCLES;
         hold_done <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // reply monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (reply_q.size() == 0) begin
               $display("%0t: reply byte %h frame_end %b with nothing expected",
                        $time, rsp.tx_byte, rsp.frame_end);
               error_count++;
            end else if (rsp.tx_byte !== reply_q[0].tx_byte ||
                         rsp.frame_end !== reply_q[0].frame_end) begin
               $display("%0t: expected tx_byte %h frame_end %b, got tx_byte %h frame_end %b",
                        $time, reply_q[0].tx_byte, reply_q[0].frame_end,
                        rsp.tx_byte, rsp.frame_end);
               error_count++;
               void'(reply_q.pop_front());
            end else begin
               void'(reply_q.pop_front());
            end
         end
         rsp.ready <= (hold_left == 0) && (quiet || $urandom_range(0, 99) >= 15);
      end
   end

   initial begin
      int r;
      int k;
      reset = 1'b1;
      req.valid = 1'b0;
      req.opcode = OP_RX;
      req.rx_byte = '0;
      req.table_address = '0;
      req.table_data = '0;
      rsp.ready = 1'b0;
      for (int i = 0; i < TABLE_BYTES; i++) table_mem[i] = 8'h00;

      // directed
      push_table_write(5'd0, 8'hFF);
      push_table_write(5'd1, 8'h00);
      push_table_write(5'd30, 8'h81);
      push_table_write(5'd31, 8'h5A);
      push_link_byte(8'hFF, 1'b1);        // nonzero while idle is dropped
      push_link_byte(8'h00, 1'b1);
      push_link_byte(8'h00, 1'b1);        // restarts, not taken as a new first byte
      push_link_byte(8'h07, 1'b1);
      push_request(16'd0, 16'd0, 1'b0);   // zero size
      push_request(16'd0, 16'd32, 1'b0);  // whole table
      push_request(16'd31, 16'hFFFF, 1'b0); // clipped to one odd byte
      push_request(16'd29, 16'd3, 1'b0);  // odd size
      push_request(16'd32, 16'd1, 1'b0);  // offset past the end
      push_request(16'hFFFF, 16'hFFFF, 1'b0);
      push_request(16'd4, 16'd4, 1'b1);   // bad crc
      for (int i = 1; i <= 4; i++) push_broken_header(i);

      // random
      mix_writes = 1'b1;
      while (stim_count < RANDOM_ITEMS) begin
         r = $urandom_range(0, 99);
         if (r < 12) begin
            push_table_write(5'($urandom), 8'($urandom));
         end else if (r < 18) begin
            push_link_byte(8'($urandom), 1'b1);
         end else if (r < 25) begin
            push_broken_header($urandom_range(1, 4));
         end else begin
            k = $urandom_range(0, 99);
            push_request((k < 80) ? 16'($urandom_range(0, TABLE_BYTES - 1)) : 16'($urandom),
                         (k % 10 < 7) ? 16'($urandom_range(0, 8)) :
                         (k % 10 < 9) ? 16'($urandom_range(0, 40)) : 16'($urandom),
                         $urandom_range(0, 99) < 10);
         end
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (link_q.size() != 0 || req.valid) @(posedge clock);
      while (reply_q.size() != 0) @(posedge clock);
      repeat (END_DRAIN) @(posedge clock);
      if (error_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule
